FILE: rtl/pdrs_pkg.sv
package pdrs_pkg;

  localparam int MW          = 50;
  localparam int KEY_W       = 18;
  localparam int IDX_W       = 10;
  localparam int DIG_W       = 9;
  localparam int BUCKETS     = 512;
  localparam int CFG_IDX_W   = 2;
  localparam int KEY_STAGES  = 10;
  localparam int FIFO_DEPTH  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CAM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Z = 2'd2;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [31:0] F_QNAN   = 32'h7fc0_0000;
  localparam logic [31:0] F_TWO    = 32'h4000_0000;
  localparam logic [31:0] KEY_BIAS = 32'h3f80_0000;

  // unrounded float: value = mant * 2^(exp - 127 - (MW-1)), or a ready special pattern
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [11:0] exp;
    logic [MW-1:0]      mant;
  } fx_t;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] particle_index;
    logic [KEY_W-1:0] distance_key;
    logic             last_entry;
    logic             valid_res;
  } res_t;

  // align and add/subtract, exact up to a sticky bit
  function automatic fx_t fadd_pre(logic [31:0] a, logic [31:0] b, logic neg_b);
    fx_t           r;
    logic          sa, sb, ia, ib, na, nb, sbig, ssml, st;
    logic [30:0]   big, sml;
    logic [7:0]    e1, e2, dif;
    logic [MW-1:0] m1, m2, sh, sum;
    r    = '0;
    sa   = a[31];
    sb   = b[31] ^ neg_b;
    ia   = (a[30:23] == 8'hff);
    ib   = (b[30:23] == 8'hff);
    na   = ia && (a[22:0] != 23'd0);
    nb   = ib && (b[22:0] != 23'd0);
    big  = a[30:0];
    sml  = b[30:0];
    sbig = sa;
    ssml = sb;
    st   = 1'b0;
    sh   = '0;
    if (na || nb || (ia && ib && (sa != sb))) begin
      r.spec     = 1'b1;
      r.spec_val = F_QNAN;
    end else if (ia) begin
      r.spec     = 1'b1;
      r.spec_val = {sa, 8'hff, 23'd0};
    end else if (ib) begin
      r.spec     = 1'b1;
      r.spec_val = {sb, 8'hff, 23'd0};
    end else begin
      if (b[30:0] > a[30:0]) begin
        big  = b[30:0];
        sml  = a[30:0];
        sbig = sb;
        ssml = sa;
      end
      e1  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      e2  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      m1  = {1'b0, big[30:23] != 8'd0, big[22:0], 25'd0};
      m2  = {1'b0, sml[30:23] != 8'd0, sml[22:0], 25'd0};
      dif = e1 - e2;
      if (dif >= 8'(MW)) begin
        st = |m2;
      end else begin
        sh = m2 >> dif;
        st = |(m2 & ~({MW{1'b1}} << dif));
      end
      sh[0]  = sh[0] | st;
      sum    = (sbig == ssml) ? (m1 + sh) : (m1 - sh);
      r.sign = (sum == '0) ? (sbig & ssml) : sbig;
      r.exp  = $signed({4'd0, e1}) + 12'sd1;
      r.mant = sum;
    end
    return r;
  endfunction

  // exact square
  function automatic fx_t fmul_sq(logic [31:0] a);
    fx_t         r;
    logic [7:0]  e1;
    logic [23:0] m;
    logic [47:0] p;
    r  = '0;
    e1 = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    m  = {a[30:23] != 8'd0, a[22:0]};
    p  = m * m;
    if (a[30:23] == 8'hff) begin
      r.spec     = 1'b1;
      r.spec_val = (a[22:0] != 23'd0) ? F_QNAN : {1'b0, 8'hff, 23'd0};
    end else begin
      r.exp  = $signed({3'd0, e1, 1'b0}) - 12'sd126;
      r.mant = {p, 2'b00};
    end
    return r;
  endfunction

  // normalize and round to nearest even
  function automatic logic [31:0] fround(fx_t x);
    logic [5:0]         lz, sh;
    logic [MW-1:0]      mn;
    logic signed [11:0] en;
    logic [11:0]        shw;
    logic               lost, g, st, up;
    logic [7:0]         ef;
    logic [30:0]        mag;
    logic [31:0]        res;
    lz = '0;
    for (int i = 0; i < MW; i++) begin
      if (x.mant[i]) lz = 6'(MW - 1 - i);
    end
    mn   = x.mant << lz;
    en   = x.exp - $signed({6'd0, lz});
    lost = 1'b0;
    ef   = en[7:0];
    if (x.spec) begin
      res = x.spec_val;
    end else if (x.mant == '0) begin
      res = {x.sign, 31'd0};
    end else if (en >= 12'sd255) begin
      res = {x.sign, 8'hff, 23'd0};
    end else begin
      if (en <= 12'sd0) begin
        shw  = 12'(12'sd1 - en);
        sh   = (shw > 12'(MW + 1)) ? 6'(MW + 1) : shw[5:0];
        lost = |(mn & ~({MW{1'b1}} << sh));
        mn   = mn >> sh;
        ef   = 8'd0;
      end
      g   = mn[MW-25];
      st  = (|mn[MW-26:0]) | lost;
      up  = g & (st | mn[MW-24]);
      mag = {ef, mn[MW-2:MW-24]} + 31'(up);
      res = {x.sign, mag};
    end
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] make_key(logic [31:0] d);
    logic [31:0] k;
    k = d - KEY_BIAS;
    return (k[31:30] != 2'b00) ? {KEY_W{1'b1}} : k[29:12];
  endfunction

endpackage

FILE: rtl/pdrs_ram.sv
module pdrs_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pdrs_key.sv
module pdrs_key import pdrs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 cmd_i,
  input  logic [31:0]          pos_x_i,
  input  logic [31:0]          pos_y_i,
  input  logic [31:0]          pos_z_i,
  output logic                 out_valid_o,
  output item_t                out_item_o
);

  logic [31:0]           cam_q [3];
  logic [31:0]           pos [3];
  logic [KEY_STAGES-1:0] v_q, c_q;

  fx_t              a1_q [3];
  logic [31:0]      d2_q [3];
  fx_t              m3_q [3];
  logic [31:0]      q4_q [3];
  fx_t              s5_q, s7_q, s9_q;
  logic [31:0]      x5_q, x6_q, s6_q, s8_q;
  logic [KEY_W-1:0] key_q;

  always_comb begin
    pos[0] = pos_x_i;
    pos[1] = pos_y_i;
    pos[2] = pos_z_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 3; j++) cam_q[j] <= '0;
      v_q <= '0;
      c_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_CAM_X: cam_q[0] <= cfg_data_i;
          CFG_CAM_Y: cam_q[1] <= cfg_data_i;
          CFG_CAM_Z: cam_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      v_q <= {v_q[KEY_STAGES-2:0], in_valid_i};
      c_q <= {c_q[KEY_STAGES-2:0], cmd_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      a1_q[j] <= fadd_pre(cam_q[j], pos[j], 1'b1);
      d2_q[j] <= fround(a1_q[j]);
      m3_q[j] <= fmul_sq(d2_q[j]);
      q4_q[j] <= fround(m3_q[j]);
    end
    s5_q  <= fadd_pre(q4_q[1], q4_q[2], 1'b0);
    x5_q  <= q4_q[0];
    s6_q  <= fround(s5_q);
    x6_q  <= x5_q;
    s7_q  <= fadd_pre(x6_q, s6_q, 1'b0);
    s8_q  <= fround(s7_q);
    s9_q  <= fadd_pre(F_TWO, s8_q, 1'b0);
    key_q <= make_key(fround(s9_q));
  end

  assign out_valid_o    = v_q[KEY_STAGES-1];
  assign out_item_o.cmd = c_q[KEY_STAGES-1];
  assign out_item_o.key = key_q;

endmodule

FILE: rtl/pdrs_fifo.sv
module pdrs_fifo import pdrs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int PW = $clog2(FIFO_DEPTH);

  item_t         mem_q [FIFO_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + PW'(1);
      if (pop_i) rp_q <= rp_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  assign item_o  = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q != (PW+1)'(FIFO_DEPTH))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: rtl/pdrs_sort.sv
module pdrs_sort import pdrs_pkg::*; #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_empty_i,
  input  item_t item_i,
  output logic  q_pop_o,
  input  logic  pop_i,
  output logic  res_valid_o,
  output res_t  res_o
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [16:0] {
    ST_IDLE = 17'h00001, ST_CLR  = 17'h00002, ST_CNT0 = 17'h00004,
    ST_CNT1 = 17'h00008, ST_CNT2 = 17'h00010, ST_PFX0 = 17'h00020,
    ST_PFX1 = 17'h00040, ST_SC1A = 17'h00080, ST_SC1B = 17'h00100,
    ST_SC1C = 17'h00200, ST_SC2A = 17'h00400, ST_SC2B = 17'h00800,
    ST_SC2C = 17'h01000, ST_SC2D = 17'h02000, ST_FRD  = 17'h04000,
    ST_FK   = 17'h08000, ST_FO   = 17'h10000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     n_q, n_d, rp_q, rp_d, i_q, i_d, n_eff;
  logic [CW-1:0]     run_lo_q, run_lo_d, run_hi_q, run_hi_d;
  logic [DIG_W-1:0]  b_q, b_d;
  logic              sorted_q, sorted_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic              out_v_q, out_v_d, res_we;
  res_t              out_q, res_d;

  logic              key_we, lo_we, hi_we, scr_we, srt_we;
  logic [AW-1:0]     key_wa, key_ra, scr_wa, scr_ra, srt_wa, srt_ra;
  logic [AW-1:0]     scr_wd, scr_rd, srt_wd, srt_rd;
  logic [KEY_W-1:0]  key_wd, key_rd;
  logic [DIG_W-1:0]  lo_wa, lo_ra, hi_wa, hi_ra;
  logic [CW-1:0]     lo_wd, lo_rd, hi_wd, hi_rd;

  pdrs_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(key_wa), .wdata_i(key_wd),
    .raddr_i(key_ra), .rdata_o(key_rd));
  pdrs_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_lo_ram (
    .clk_i, .we_i(lo_we), .waddr_i(lo_wa), .wdata_i(lo_wd),
    .raddr_i(lo_ra), .rdata_o(lo_rd));
  pdrs_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_hi_ram (
    .clk_i, .we_i(hi_we), .waddr_i(hi_wa), .wdata_i(hi_wd),
    .raddr_i(hi_ra), .rdata_o(hi_rd));
  pdrs_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_scr_ram (
    .clk_i, .we_i(scr_we), .waddr_i(scr_wa), .wdata_i(scr_wd),
    .raddr_i(scr_ra), .rdata_o(scr_rd));
  pdrs_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_srt_ram (
    .clk_i, .we_i(srt_we), .waddr_i(srt_wa), .wdata_i(srt_wd),
    .raddr_i(srt_ra), .rdata_o(srt_rd));

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    rp_d     = rp_q;
    i_d      = i_q;
    b_d      = b_q;
    run_lo_d = run_lo_q;
    run_hi_d = run_hi_q;
    sorted_d = sorted_q;
    key_d    = key_q;
    idx_d    = idx_q;
    n_eff    = sorted_q ? '0 : n_q;
    q_pop_o  = 1'b0;
    res_we   = 1'b0;
    res_d    = '0;
    key_we = 1'b0; key_wa = '0; key_wd = '0; key_ra = '0;
    lo_we  = 1'b0; lo_wa  = '0; lo_wd  = '0; lo_ra  = '0;
    hi_we  = 1'b0; hi_wa  = '0; hi_wd  = '0; hi_ra  = '0;
    scr_we = 1'b0; scr_wa = '0; scr_wd = '0; scr_ra = '0;
    srt_we = 1'b0; srt_wa = '0; srt_wd = '0; srt_ra = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i && (!out_v_q || pop_i)) begin
          q_pop_o = 1'b1;
          if (item_i.cmd == CMD_ADD) begin
            sorted_d = 1'b0;
            if (sorted_q) rp_d = '0;
            n_d = n_eff;
            if (n_eff < CW'(MAX_ITEMS)) begin
              key_we = 1'b1;
              key_wa = n_eff[AW-1:0];
              key_wd = item_i.key;
              n_d    = n_eff + CW'(1);
            end
            res_we = 1'b1;
          end else if (sorted_q) begin
            state_d = ST_FRD;
          end else begin
            b_d     = '0;
            state_d = ST_CLR;
          end
        end
      end
      ST_CLR: begin
        lo_we = 1'b1;
        lo_wa = b_q;
        hi_we = 1'b1;
        hi_wa = b_q;
        b_d   = b_q + DIG_W'(1);
        if (b_q == {DIG_W{1'b1}}) begin
          i_d     = '0;
          state_d = ST_CNT0;
        end
      end
      ST_CNT0: begin
        if (i_q == n_q) begin
          b_d      = '0;
          run_lo_d = '0;
          run_hi_d = '0;
          state_d  = ST_PFX0;
        end else begin
          key_ra  = i_q[AW-1:0];
          state_d = ST_CNT1;
        end
      end
      ST_CNT1: begin
        lo_ra   = key_rd[DIG_W-1:0];
        hi_ra   = key_rd[KEY_W-1:DIG_W];
        key_d   = key_rd;
        state_d = ST_CNT2;
      end
      ST_CNT2: begin
        lo_we   = 1'b1;
        lo_wa   = key_q[DIG_W-1:0];
        lo_wd   = lo_rd + CW'(1);
        hi_we   = 1'b1;
        hi_wa   = key_q[KEY_W-1:DIG_W];
        hi_wd   = hi_rd + CW'(1);
        i_d     = i_q + CW'(1);
        state_d = ST_CNT0;
      end
      ST_PFX0: begin
        lo_ra   = b_q;
        hi_ra   = b_q;
        state_d = ST_PFX1;
      end
      ST_PFX1: begin
        lo_we    = 1'b1;
        lo_wa    = b_q;
        lo_wd    = run_lo_q;
        hi_we    = 1'b1;
        hi_wa    = b_q;
        hi_wd    = run_hi_q;
        run_lo_d = run_lo_q + lo_rd;
        run_hi_d = run_hi_q + hi_rd;
        b_d      = b_q + DIG_W'(1);
        if (b_q == {DIG_W{1'b1}}) begin
          i_d     = '0;
          state_d = ST_SC1A;
        end else begin
          state_d = ST_PFX0;
        end
      end
      ST_SC1A: begin
        if (i_q == n_q) begin
          i_d     = '0;
          state_d = ST_SC2A;
        end else begin
          key_ra  = i_q[AW-1:0];
          state_d = ST_SC1B;
        end
      end
      ST_SC1B: begin
        lo_ra   = key_rd[DIG_W-1:0];
        key_d   = key_rd;
        state_d = ST_SC1C;
      end
      ST_SC1C: begin
        scr_we  = 1'b1;
        scr_wa  = lo_rd[AW-1:0];
        scr_wd  = i_q[AW-1:0];
        lo_we   = 1'b1;
        lo_wa   = key_q[DIG_W-1:0];
        lo_wd   = lo_rd + CW'(1);
        i_d     = i_q + CW'(1);
        state_d = ST_SC1A;
      end
      ST_SC2A: begin
        if (i_q == n_q) begin
          sorted_d = 1'b1;
          rp_d     = '0;
          state_d  = ST_FRD;
        end else begin
          scr_ra  = i_q[AW-1:0];
          state_d = ST_SC2B;
        end
      end
      ST_SC2B: begin
        key_ra  = scr_rd;
        idx_d   = scr_rd;
        state_d = ST_SC2C;
      end
      ST_SC2C: begin
        hi_ra   = key_rd[KEY_W-1:DIG_W];
        key_d   = key_rd;
        state_d = ST_SC2D;
      end
      ST_SC2D: begin
        srt_we  = 1'b1;
        srt_wa  = hi_rd[AW-1:0];
        srt_wd  = idx_q;
        hi_we   = 1'b1;
        hi_wa   = key_q[KEY_W-1:DIG_W];
        hi_wd   = hi_rd + CW'(1);
        i_d     = i_q + CW'(1);
        state_d = ST_SC2A;
      end
      ST_FRD: begin
        if (rp_q < n_q) begin
          srt_ra  = rp_q[AW-1:0];
          state_d = ST_FK;
        end else begin
          res_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FK: begin
        key_ra  = srt_rd;
        idx_d   = srt_rd;
        state_d = ST_FO;
      end
      ST_FO: begin
        res_we               = 1'b1;
        res_d.particle_index = IDX_W'(idx_q);
        res_d.distance_key   = key_rd;
        res_d.last_entry     = (rp_q + CW'(1) == n_q);
        res_d.valid_res      = 1'b1;
        rp_d                 = rp_q + CW'(1);
        state_d              = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_v_d = out_v_q;
    if (res_we) begin
      out_v_d = 1'b1;
    end else if (pop_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      n_q      <= '0;
      rp_q     <= '0;
      i_q      <= '0;
      b_q      <= '0;
      run_lo_q <= '0;
      run_hi_q <= '0;
      sorted_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      rp_q     <= rp_d;
      i_q      <= i_d;
      b_q      <= b_d;
      run_lo_q <= run_lo_d;
      run_hi_q <= run_hi_d;
      sorted_q <= sorted_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    idx_q <= idx_d;
    if (res_we) begin
      out_q <= res_d;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(MAX_ITEMS))
    else $error("list length beyond capacity");
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= n_q)
    else $error("read pointer past list length");
  a_fetch_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FO |=> rp_q == $past(rp_q) + CW'(1))
    else $error("read pointer did not advance after an entry");

endmodule

FILE: rtl/particle_depth_radix_sort.sv
// Particle depth sorter. Add requests (cmd 0) carry a particle position; a ten-stage
// float pipeline forms 2 + |camera - pos|^2 with round-to-nearest-even and turns it into
// an 18-bit key, one add per cycle while not full, and the back end stores the key as
// it pops the add. The first fetch request (cmd 1) after loading runs a two-pass radix
// sort over n stored items: clear the bucket counters, count, prefix sums, then the two
// scatter passes, each paced by the single read port of each buffer. Every later fetch
// steps through the read, key and output states, and past the end of the list returns
// from the read state. Each request yields one result; adds and fetches past the end
// give an all-zero result. An add after a fetch starts a new list. The user must write
// the camera registers only while the block is idle; the block does not enforce this.
module particle_depth_radix_sort import pdrs_pkg::*; #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  logic                 cmd_i,
  input  logic [31:0]          pos_x_i,
  input  logic [31:0]          pos_y_i,
  input  logic [31:0]          pos_z_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [IDX_W-1:0]     particle_index_o,
  output logic [KEY_W-1:0]     distance_key_o,
  output logic                 last_entry_o,
  output logic                 valid_res_o
);

  localparam int OW = $clog2(FIFO_DEPTH + 1);

  logic          acc, key_v, q_empty, q_pop, res_v;
  item_t         key_item, q_item;
  res_t          res;
  logic [OW-1:0] occ_q, occ_d;

  assign cfg_ready_o = 1'b1;
  assign full        = (occ_q >= OW'(FIFO_DEPTH));
  assign acc         = push && !full;
  assign occ_d       = occ_q + OW'(acc) - OW'(q_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  pdrs_key u_key (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_valid_i), .cfg_index_i, .cfg_data_i,
    .in_valid_i(acc), .cmd_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .out_valid_o(key_v), .out_item_o(key_item));

  pdrs_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(key_v), .item_i(key_item),
    .pop_i(q_pop), .item_o(q_item), .empty_o(q_empty));

  pdrs_sort #(.MAX_ITEMS(MAX_ITEMS)) u_sort (
    .clk_i, .rst_ni,
    .q_empty_i(q_empty), .item_i(q_item), .q_pop_o(q_pop),
    .pop_i(pop && !empty), .res_valid_o(res_v), .res_o(res));

  assign empty            = !res_v;
  assign particle_index_o = res.particle_index;
  assign distance_key_o   = res.distance_key;
  assign last_entry_o     = res.last_entry;
  assign valid_res_o      = res.valid_res;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(FIFO_DEPTH))
    else $error("requests in flight exceed queue room");
  a_occ_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> occ_q != '0)
    else $error("queue pop with nothing in flight");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(particle_index_o) && $stable(distance_key_o)
      && $stable(last_entry_o) && $stable(valid_res_o))
    else $error("waiting result changed before it was taken");

endmodule
